// ===== design/lj_pkg.sv =====
`timescale 1ns / 1ps

package lj_pkg;

    localparam int WIDE_W   = 288;
    localparam int CHUNK_W  = 32;
    localparam int N_CHUNKS = WIDE_W / CHUNK_W;
    localparam int QUO_W    = 49;
    localparam int DIM      = 3;
    localparam int CNT_W    = 6;

    localparam logic [47:0] MAX_POS48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MIN_NEG48 = 48'h8000_0000_0000;

    typedef logic [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [47:0] lj6;
        logic [46:0]        lj12;
        logic               scaled_14;
    } pair_t;

    typedef struct packed {
        logic signed [47:0] energy;
        logic signed [47:0] grad_x;
        logic signed [47:0] grad_y;
        logic signed [47:0] grad_z;
        logic               in_range;
        logic               saturated;
    } result_t;

    typedef enum logic [1:0] {
        JOB_BEYOND,
        JOB_ZERO,
        JOB_CALC
    } job_kind_t;

    typedef struct packed {
        job_kind_t             kind;
        logic [31:0]           r2;
        logic [DIM-1:0][32:0]  dmag;
        logic [DIM-1:0]        dneg;
        logic [47:0]           mag6;
        logic                  neg6;
        logic [46:0]           lj12;
        logic                  half;
    } job_t;

    // signed sum of a possibly negated a and a non-negative b, as sign and magnitude
    function automatic logic [WIDE_W:0] combine(input logic nega, input wide_t a,
                                                input wide_t b);
        logic [WIDE_W:0] r;
        if (!nega)
            r = {1'b0, a + b};
        else if (a > b)
            r = {1'b1, a - b};
        else
            r = {1'b0, b - a};
        return r;
    endfunction

    // clip a quotient magnitude to the 48-bit signed range; top bit flags a clip
    function automatic logic [48:0] clip48(input logic [QUO_W-1:0] q, input logic neg);
        logic [47:0] lim;
        logic [47:0] v;
        logic        sat;
        lim = neg ? MIN_NEG48 : MAX_POS48;
        sat = q[QUO_W-1] || (q[47:0] > lim);
        v   = sat ? lim : q[47:0];
        return {sat, neg ? (~v + 48'd1) : v};
    endfunction

endpackage

// ===== design/lj_fifo.sv =====
`timescale 1ns / 1ps

module lj_fifo #(
    parameter int DEPTH = 4,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lj_pkg::job_t   wdata,
    input  logic           pop,
    output lj_pkg::job_t   rdata,
    output logic           empty,
    output logic [CW-1:0]  count
);

    localparam int PTR_W = $clog2(DEPTH);

    lj_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// ===== design/lj_front.sv =====
`timescale 1ns / 1ps

module lj_front #(
    parameter int FRAC_BITS = 16,
    parameter int DEPTH     = 4,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lj_pkg::pair_t  pair,
    output logic           busy,
    input  logic [31:0]    cutoff_sq,
    input  logic [CW-1:0]  fifo_count,
    output logic           push,
    output lj_pkg::job_t   job
);

    localparam int DIM = lj_pkg::DIM;

    logic              s1_valid_reg;
    logic [65:0]       sq_reg   [DIM];
    logic [32:0]       dmag_reg [DIM];
    logic [DIM-1:0]    dneg_reg;
    logic [47:0]       mag6_reg;
    logic              neg6_reg;
    logic [46:0]       lj12_reg;
    logic              half_reg;

    logic [31:0]       a_c [DIM];
    logic [31:0]       b_c [DIM];
    logic [32:0]       d_c [DIM];
    logic [32:0]       dmag_c [DIM];
    logic [65:0]       sq_c [DIM];
    logic [47:0]       v6;
    logic              accept;
    logic [67:0]       sum;
    logic [67:0]       r2w;

    assign accept = start && !busy;
    assign busy   = ({1'b0, fifo_count} + (CW + 1)'(s1_valid_reg)) >= (CW + 1)'(DEPTH);

    assign a_c[0] = pair.ax;
    assign a_c[1] = pair.ay;
    assign a_c[2] = pair.az;
    assign b_c[0] = pair.bx;
    assign b_c[1] = pair.by;
    assign b_c[2] = pair.bz;
    assign v6     = pair.lj6;

    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            d_c[i]    = {b_c[i][31], b_c[i]} - {a_c[i][31], a_c[i]};
            dmag_c[i] = d_c[i][32] ? (~d_c[i] + 33'd1) : d_c[i];
            sq_c[i]   = {33'b0, dmag_c[i]} * {33'b0, dmag_c[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                sq_reg[i]   <= sq_c[i];
                dmag_reg[i] <= dmag_c[i];
                dneg_reg[i] <= d_c[i][32];
            end
            neg6_reg <= v6[47];
            mag6_reg <= v6[47] ? (~v6 + 48'd1) : v6;
            lj12_reg <= pair.lj12;
            half_reg <= pair.scaled_14;
        end
    end

    assign sum = 68'(sq_reg[0]) + 68'(sq_reg[1]) + 68'(sq_reg[2]);
    assign r2w = sum >> FRAC_BITS;

    always_comb
    begin
        if (r2w > 68'(cutoff_sq))
            job.kind = lj_pkg::JOB_BEYOND;
        else if (r2w == '0)
            job.kind = lj_pkg::JOB_ZERO;
        else
            job.kind = lj_pkg::JOB_CALC;
        job.r2 = r2w[31:0];
        for (int i = 0; i < DIM; i++)
        begin
            job.dmag[i] = dmag_reg[i];
        end
        job.dneg = dneg_reg;
        job.mag6 = mag6_reg;
        job.neg6 = neg6_reg;
        job.lj12 = lj12_reg;
        job.half = half_reg;
    end

    assign push = s1_valid_reg;

endmodule

// ===== design/lj_back.sv =====
`timescale 1ns / 1ps

module lj_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  lj_pkg::job_t     head,
    output logic             pop,
    output lj_pkg::result_t  result,
    output logic             done
);

    localparam int WIDE_W   = lj_pkg::WIDE_W;
    localparam int CHUNK_W  = lj_pkg::CHUNK_W;
    localparam int N_CHUNKS = lj_pkg::N_CHUNKS;
    localparam int QUO_W    = lj_pkg::QUO_W;
    localparam int CNT_W    = lj_pkg::CNT_W;
    localparam int SH3      = 3 * FRAC_BITS;
    localparam int SH6      = 6 * FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_NEXT
    } state_t;

    typedef enum logic [4:0] {
        SP_R2, SP_R3, SP_R4, SP_R5, SP_R6, SP_R7,
        SP_A1, SP_A2, SP_A3, SP_DIV_E,
        SP_MUL_X, SP_DIV_X, SP_MUL_Y, SP_DIV_Y, SP_MUL_Z, SP_DIV_Z,
        SP_END
    } step_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    lj_pkg::job_t      job_reg, job_next;
    lj_pkg::wide_t     mx_reg, mx_next;
    logic [32:0]       my_reg, my_next;
    lj_pkg::wide_t     macc_reg, macc_next;
    lj_pkg::wide_t     d6_reg, d6_next;
    lj_pkg::wide_t     r7_reg, r7_next;
    lj_pkg::wide_t     a6_reg, a6_next;
    lj_pkg::wide_t     ng_reg, ng_next;
    lj_pkg::wide_t     rem_reg, rem_next;
    lj_pkg::wide_t     dsh_reg, dsh_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic              nege_reg, nege_next;
    logic              negg_reg, negg_next;
    logic              sat_reg, sat_next;
    lj_pkg::result_t   res_reg, res_next;
    logic              done_reg, done_next;

    logic [64:0]       prod;
    logic              div_ge;
    lj_pkg::wide_t     ash;
    lj_pkg::wide_t     bsh;
    lj_pkg::wide_t     b12sh;
    logic [50:0]       lj12x12;
    logic [WIDE_W:0]   comb_e;
    logic [WIDE_W:0]   comb_g;
    lj_pkg::wide_t     den_sel;
    lj_pkg::wide_t     den_h;
    lj_pkg::wide_t     dsh_init;
    logic              clip_neg;
    logic [48:0]       clip;
    logic [47:0]       zero_energy;

    assign prod    = 65'(mx_reg[WIDE_W-1 -: CHUNK_W]) * 65'(my_reg);
    assign div_ge  = rem_reg >= dsh_reg;
    assign ash     = macc_reg << SH3;
    assign bsh     = WIDE_W'(job_reg.lj12) << SH6;
    assign lj12x12 = ({4'b0, job_reg.lj12} << 3) + ({4'b0, job_reg.lj12} << 2);
    assign b12sh   = WIDE_W'(lj12x12) << SH6;
    assign comb_e  = lj_pkg::combine(job_reg.neg6, ash, bsh);
    assign comb_g  = lj_pkg::combine(job_reg.neg6, a6_reg, b12sh);
    assign den_sel = (step_reg == SP_DIV_E) ? d6_reg : r7_reg;
    assign den_h   = job_reg.half ? (den_sel << 1) : den_sel;
    assign dsh_init = den_h << (QUO_W - 1);

    always_comb
    begin
        unique case (step_reg)
            SP_MUL_X: clip_neg = nege_reg;
            SP_MUL_Y: clip_neg = negg_reg ^ job_reg.dneg[0];
            SP_MUL_Z: clip_neg = negg_reg ^ job_reg.dneg[1];
            SP_END:   clip_neg = negg_reg ^ job_reg.dneg[2];
            default:  clip_neg = 1'b0;
        endcase
    end

    assign clip = lj_pkg::clip48(q_reg, clip_neg);

    // energy at zero distance follows the sign of the dominant term
    always_comb
    begin
        if (head.lj12 != '0 || (!head.neg6 && head.mag6 != '0))
            zero_energy = lj_pkg::MAX_POS48;
        else if (head.neg6)
            zero_energy = lj_pkg::MIN_NEG48;
        else
            zero_energy = '0;
    end

    assign pop = (state_reg == ST_IDLE) && !empty;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        macc_next  = macc_reg;
        d6_next    = d6_reg;
        r7_next    = r7_reg;
        a6_next    = a6_reg;
        ng_next    = ng_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        nege_next  = nege_reg;
        negg_next  = negg_reg;
        sat_next   = sat_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    job_next = head;
                    res_next = '0;
                    unique case (head.kind)
                        lj_pkg::JOB_BEYOND:
                        begin
                            done_next = 1'b1;
                        end
                        lj_pkg::JOB_ZERO:
                        begin
                            res_next.energy    = zero_energy;
                            res_next.in_range  = 1'b1;
                            res_next.saturated = 1'b1;
                            done_next          = 1'b1;
                        end
                        default:
                        begin
                            res_next.in_range = 1'b1;
                            sat_next   = 1'b0;
                            mx_next    = WIDE_W'(head.r2);
                            my_next    = 33'(head.r2);
                            macc_next  = '0;
                            cnt_next   = '0;
                            step_next  = SP_R2;
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                macc_next = (macc_reg << CHUNK_W) + WIDE_W'(prod);
                mx_next   = mx_reg << CHUNK_W;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_CHUNKS - 1))
                begin
                    step_next  = step_t'(step_reg + 1'b1);
                    state_next = ST_NEXT;
                end
            end

            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[QUO_W-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    step_next  = step_t'(step_reg + 1'b1);
                    state_next = ST_NEXT;
                end
            end

            default:
            begin
                cnt_next  = '0;
                macc_next = '0;
                rem_next  = macc_reg;
                dsh_next  = dsh_init;
                q_next    = '0;
                my_next   = 33'(job_reg.r2);
                mx_next   = macc_reg;
                unique case (step_reg)
                    SP_R3, SP_R4, SP_R5, SP_R6, SP_A2, SP_A3:
                    begin
                        state_next = ST_MUL;
                    end
                    SP_R7:
                    begin
                        d6_next    = macc_reg;
                        state_next = ST_MUL;
                    end
                    SP_A1:
                    begin
                        r7_next    = macc_reg;
                        mx_next    = WIDE_W'(job_reg.mag6);
                        state_next = ST_MUL;
                    end
                    SP_DIV_E:
                    begin
                        a6_next    = (ash << 2) + (ash << 1);
                        nege_next  = comb_e[WIDE_W];
                        rem_next   = comb_e[WIDE_W-1:0];
                        state_next = ST_DIV;
                    end
                    SP_MUL_X:
                    begin
                        res_next.energy = clip[47:0];
                        sat_next   = sat_reg | clip[48];
                        negg_next  = comb_g[WIDE_W];
                        ng_next    = comb_g[WIDE_W-1:0];
                        mx_next    = comb_g[WIDE_W-1:0];
                        my_next    = job_reg.dmag[0];
                        state_next = ST_MUL;
                    end
                    SP_DIV_X, SP_DIV_Y, SP_DIV_Z:
                    begin
                        state_next = ST_DIV;
                    end
                    SP_MUL_Y:
                    begin
                        res_next.grad_x = clip[47:0];
                        sat_next   = sat_reg | clip[48];
                        mx_next    = ng_reg;
                        my_next    = job_reg.dmag[1];
                        state_next = ST_MUL;
                    end
                    SP_MUL_Z:
                    begin
                        res_next.grad_y = clip[47:0];
                        sat_next   = sat_reg | clip[48];
                        mx_next    = ng_reg;
                        my_next    = job_reg.dmag[2];
                        state_next = ST_MUL;
                    end
                    SP_END:
                    begin
                        res_next.grad_z    = clip[47:0];
                        res_next.saturated = sat_reg | clip[48];
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= SP_R2;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        job_reg  <= job_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        macc_reg <= macc_next;
        d6_reg   <= d6_next;
        r7_reg   <= r7_next;
        a6_reg   <= a6_next;
        ng_reg   <= ng_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        nege_reg <= nege_next;
        negg_reg <= negg_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// ===== design/lennard_jones_pair_energy_force_unit.sv =====
`timescale 1ns / 1ps
// in range the back end holds a pair through the pop, 12 products on the shared
//   32x33 multiplier, 4 quotients on the 1-bit divider and a sequencing state after each
// throughput: one pair per cycle while the queue has room; in-range results one at a time,
//   others one per cycle while the back end is idle, in order; the receiver cannot stall
// reset: rst_n asynchronous, clears queue and sequencer, cutoff_sq returns to 1048576

module lennard_jones_pair_energy_force_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lj_pkg::pair_t    pair,
    output logic             busy,
    output lj_pkg::result_t  result,
    output logic             done,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]   cutoff_sq_reg;
    logic          push;
    logic          pop;
    logic          empty;
    logic [CW-1:0] count;
    lj_pkg::job_t  job_in;
    lj_pkg::job_t  job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_sq_reg <= 32'd1048576;
        end
        else if (cfg_we)
        begin
            cutoff_sq_reg <= cfg_wdata;
        end
    end

    lj_front #(
        .FRAC_BITS (FRAC_BITS),
        .DEPTH     (QUEUE_DEPTH),
        .CW        (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pair       (pair),
        .busy       (busy),
        .cutoff_sq  (cutoff_sq_reg),
        .fifo_count (count),
        .push       (push),
        .job        (job_in)
    );

    lj_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .empty (empty),
        .count (count)
    );

    lj_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (job_out),
        .pop    (pop),
        .result (result),
        .done   (done)
    );

endmodule

// ===== tb/sv/tb_lennard_jones_pair_energy_force_unit.sv =====
`timescale 1ns / 1ps

module tb_lennard_jones_pair_energy_force_unit;

    localparam int WATCHDOG_LIMIT = 6000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    lj_pkg::pair_t   pair = '0;
    logic            busy;
    lj_pkg::result_t result;
    logic            done;
    logic            cfg_we = 1'b0;
    logic [31:0]     cfg_wdata = '0;

    lj_pkg::result_t pending_results[$];
    logic [31:0]     cutoff_model = 32'd1048576;
    int              mismatches = 0;
    int              idle_pct = 0;
    int              stall_count = 0;

    lennard_jones_pair_energy_force_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .pair      (pair),
        .busy      (busy),
        .result    (result),
        .done      (done),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [47:0] clip_q48(input lj_pkg::wide_t q, input logic neg,
                                             inout logic sat);
        lj_pkg::wide_t lim;
        lim = neg ? (lj_pkg::wide_t'(1) << 47) : ((lj_pkg::wide_t'(1) << 47) - 1);
        if (q > lim)
        begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? (48'd0 - q[47:0]) : q[47:0];
    endfunction

    function automatic lj_pkg::result_t lj_energy_force(input lj_pkg::pair_t p,
                                                        input logic [31:0] cut);
        logic signed [32:0] av[3];
        logic signed [32:0] bv[3];
        logic signed [32:0] d;
        logic [32:0]        dm[3];
        logic               dn[3];
        logic [65:0]        sum;
        logic [65:0]        r2;
        logic               neg6;
        logic               neg_e;
        logic               neg_g;
        logic               sat;
        logic [47:0]        mag6;
        logic [47:0]        g[3];
        lj_pkg::wide_t      rr, r3, r6, r7, ta, tb, ne, ng, den;
        lj_pkg::result_t    r;
        av[0] = p.ax; av[1] = p.ay; av[2] = p.az;
        bv[0] = p.bx; bv[1] = p.by; bv[2] = p.bz;
        sum = '0;
        r   = '0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d     = bv[i] - av[i];
            dn[i] = d[32];
            dm[i] = d[32] ? -d : d;
            sum   = sum + 66'(dm[i]) * 66'(dm[i]);
        end
        r2 = sum >> 16;
        if (r2 > 66'(cut))
            return r;
        r.in_range = 1'b1;
        neg6 = p.lj6[47];
        mag6 = neg6 ? -p.lj6 : p.lj6;
        if (r2 == 0)
        begin
            if (p.lj12 != 0 || (!neg6 && mag6 != 0))
                r.energy = lj_pkg::MAX_POS48;
            else if (neg6)
                r.energy = lj_pkg::MIN_NEG48;
            r.saturated = 1'b1;
            return r;
        end
        rr = lj_pkg::wide_t'(r2);
        r3 = rr * rr * rr;
        r6 = r3 * r3;
        r7 = r6 * rr;
        ta = (lj_pkg::wide_t'(mag6) << 48) * r3;
        tb = lj_pkg::wide_t'(p.lj12) << 96;
        if (!neg6)
        begin
            ne = ta + tb; neg_e = 1'b0;
        end
        else if (ta > tb)
        begin
            ne = ta - tb; neg_e = 1'b1;
        end
        else
        begin
            ne = tb - ta; neg_e = 1'b0;
        end
        den = r6 << p.scaled_14;
        r.energy = clip_q48(ne / den, neg_e, sat);
        ta = ta * 6;
        tb = tb * 12;
        if (!neg6)
        begin
            ng = ta + tb; neg_g = 1'b0;
        end
        else if (ta > tb)
        begin
            ng = ta - tb; neg_g = 1'b1;
        end
        else
        begin
            ng = tb - ta; neg_g = 1'b0;
        end
        den = r7 << p.scaled_14;
        for (int i = 0; i < 3; i++)
            g[i] = clip_q48((ng * lj_pkg::wide_t'(dm[i])) / den, neg_g != dn[i], sat);
        r.grad_x    = g[0];
        r.grad_y    = g[1];
        r.grad_z    = g[2];
        r.saturated = sat;
        return r;
    endfunction

    // result checker
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", result);
            end
            else
            begin
                lj_pkg::result_t want;
                want = pending_results.pop_front();
                if (result.energy !== want.energy || result.grad_x !== want.grad_x ||
                    result.grad_y !== want.grad_y || result.grad_z !== want.grad_z ||
                    result.in_range !== want.in_range ||
                    result.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, result);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_pair(input lj_pkg::pair_t p);
        logic taken;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pair  <= p;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pending_results.push_back(lj_energy_force(p, cutoff_model));
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cutoff(input logic [31:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cutoff_model = v;
        @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom} >> $urandom_range(0, 47));
    endfunction

    function automatic lj_pkg::pair_t make_pair(input logic [31:0] a0,
                                                input logic [31:0] a1,
                                                input logic [31:0] a2,
                                                input logic [31:0] b0,
                                                input logic [31:0] b1,
                                                input logic [31:0] b2,
                                                input logic [47:0] c6,
                                                input logic [46:0] c12,
                                                input logic s14);
        lj_pkg::pair_t p;
        p.ax = a0; p.ay = a1; p.az = a2;
        p.bx = b0; p.by = b1; p.bz = b2;
        p.lj6 = c6; p.lj12 = c12; p.scaled_14 = s14;
        return p;
    endfunction

    function automatic lj_pkg::pair_t random_pair();
        lj_pkg::pair_t p;
        logic [31:0]   a[3];
        logic [31:0]   b[3];
        logic [47:0]   c6;
        int            span;
        span = $urandom_range(0, 20);
        for (int i = 0; i < 3; i++)
        begin
            a[i] = $urandom;
            if ($urandom_range(9) == 0)
                b[i] = $urandom;
            else
                b[i] = a[i] + (($urandom >> (32 - span - 1)) - (32'd1 << span));
        end
        c6 = 48'({$urandom, $urandom});
        if ($urandom_range(3) != 0)
            c6 = $signed(c6) >>> $urandom_range(0, 47);
        p = make_pair(a[0], a[1], a[2], b[0], b[1], b[2], c6,
                      47'(rand48()), 1'($urandom_range(1)));
        return p;
    endfunction

    task automatic test_directed;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 48'd100, 47'd0, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, -48'sd100, 47'd0, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 48'd0, 47'd0, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, -48'sd5, 47'd3, 1'b1));
        send_pair(make_pair(5, 5, 5, 6, 5, 5, 48'd9, 47'd9, 1'b0));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            lj_pkg::MIN_NEG48, {47{1'b1}}, 1'b1));
        send_pair(make_pair(0, 0, 0, 32'h100, 0, 0, lj_pkg::MAX_POS48, {47{1'b1}}, 1'b0));
        send_pair(make_pair(0, 0, 0, -32'sh100, 0, 0, lj_pkg::MIN_NEG48, 47'd0, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 48'hFFFF_FFF0_0000,
                            47'h0001_0000_0000, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 48'hFFFF_FFF0_0000,
                            47'h0001_0000_0000, 1'b1));
        send_pair(make_pair(32'h10000, 0, 32'h20000, 0, 32'h18000, 0,
                            -48'sd4000000, 47'd4000000, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h40000, 0, 0, 48'd65536, 47'd65536, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h40001, 0, 0, 48'd65536, 47'd65536, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 32'h20000, 32'h20000, lj_pkg::MAX_POS48, 47'd0,
                            1'b1));
        send_pair(make_pair(7, 7, 7, 7, 7, 7, 48'd0, 47'd1, 1'b0));
        drain();
    endtask

    task automatic test_cutoff_extremes;
        write_cutoff(32'd0);
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 48'd1, 47'd0, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h100, 0, 0, 48'd1, 47'd1, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'hFF, 0, 0, 48'd1, 47'd1, 1'b0));
        write_cutoff(32'hFFFF_FFFF);
        send_pair(make_pair(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 48'd77, 47'd77, 1'b0));
        send_pair(make_pair(0, 0, 0, 32'h0100_0000, 32'h00FF_FFFF, 0, -48'sd1,
                            47'd5, 1'b1));
        drain();
    endtask

    task automatic test_random(input int n, input int pct, input logic [31:0] cut);
        write_cutoff(cut);
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain();
            send_pair(random_pair());
        end
        idle_pct = 0;
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_cutoff_extremes();
        test_random(500, 0, 32'd1048576);
        test_random(500, 81, 32'd262144);
        test_random(450, 0, 32'hFFFF_FFFF);
        test_random(500, 12, 32'd4194304);
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
